[sv/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

  localparam int unsigned HUE_FRACTION_BITS_DEFAULT = 4;
  localparam int unsigned DEG_PER_SECTOR = 60;
  localparam int unsigned SECTOR_COUNT = 6;
  localparam int unsigned CH_MAX = 255;
  localparam int unsigned HUE_W = 16;
  localparam int unsigned CH_W = 8;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] brightness;
    logic [CH_W-1:0] alpha_in;
  } hsv_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha_out;
  } rgb_beat_t;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

endpackage

[sv/hsv2rgb_cdiv.sv]
module hsv2rgb_cdiv import hsv2rgb_pkg::*; #(
  parameter int unsigned DIVISOR = 510,
  parameter int unsigned XW = 17,
  parameter int unsigned QW = 8
) (
  input  logic clk,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q,
  output logic [$clog2(DIVISOR)-1:0] rem
);

  localparam int unsigned SHIFT = 32;
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / DIVISOR;
  localparam int unsigned RW = $clog2(RECIP + 1);
  localparam int unsigned PW = XW + RW;
  localparam int unsigned RMW = $clog2(DIVISOR);

  logic [PW-1:0] prod;
  logic [XW-1:0] x_b;
  logic [QW-1:0] q_est;
  logic [XW-1:0] r_full;

  // reciprocal estimate, low by at most one
  always_ff @(posedge clk) begin
    prod <= PW'(x) * PW'(RW'(RECIP));
    x_b  <= x;
  end

  assign q_est  = QW'(prod >> SHIFT);
  assign r_full = x_b - XW'(q_est) * XW'(DIVISOR);

  always_ff @(posedge clk) begin
    if (r_full >= XW'(DIVISOR)) begin
      q   <= q_est + QW'(1);
      rem <= RMW'(r_full - XW'(DIVISOR));
    end else begin
      q   <= q_est;
      rem <= RMW'(r_full);
    end
  end

endmodule

[sv/hsv_to_rgb_converter_core.sv]
// channel  ports                 dir  beat accepted when
// command  start, busy, hsv      in   start high and busy low (busy high only in reset)
// result   done, rgb             out  done high, one cycle, no hold-off
//
// one pixel per clock outside reset
// the path holds three constant dividers (hue wrap, then smallest and middle channel rounding)
// synchronous reset clears the valid pipeline and done only, no state beyond them
// the receiver cannot stall, so nothing ever backs up
module hsv_to_rgb_converter_core import hsv2rgb_pkg::*; #(
  parameter int unsigned HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  hsv_beat_t hsv,
  output logic done,
  output rgb_beat_t rgb
);

  localparam int unsigned U = DEG_PER_SECTOR << HUE_FRACTION_BITS;
  localparam int unsigned T = SECTOR_COUNT * U;
  localparam int unsigned HUE_SPAN = 1 << HUE_W;
  localparam int unsigned HUE_BIAS = HUE_SPAN / 2;
  localparam int unsigned WRAP_OFFSET = T - (HUE_BIAS % T);
  localparam int unsigned YMAX = HUE_SPAN - 1 + T;
  localparam int unsigned YW = $clog2(YMAX + 1);
  localparam int unsigned YQW = $clog2(YMAX / T + 1);
  localparam int unsigned WW = $clog2(T);
  localparam int unsigned UW = $clog2(U + 1);
  localparam int unsigned PMW = 2 * CH_W;
  localparam int unsigned PMAX = CH_MAX * CH_MAX;
  localparam int unsigned D = CH_MAX * U;
  localparam int unsigned MID_DIV = 2 * D;
  localparam int unsigned MIDXW = $clog2(2 * PMAX * U + D + 1);
  localparam int unsigned LO_DIV = 2 * CH_MAX;
  localparam int unsigned LOXW = $clog2(2 * PMAX + CH_MAX + 1);
  localparam int unsigned CNW = PMW + UW;

  logic [7:1] vld;

  logic [YW-1:0] y1;
  logic [CH_W-1:0] s1, v1;
  logic [CH_W-1:0] v2, v3, v4, v5, v6, v7;
  logic [CH_W-1:0] a1, a2, a3, a4, a5, a6, a7;
  logic [PMW-1:0] c2, c3, c4, m2, m3, m4;
  logic [WW-1:0] w3;
  sector_t sector4, sector5, sector6, sector7;
  sector_t sector_next;
  logic [UW-1:0] n4, n_next;
  logic [WW-1:0] base, rem_w;
  logic [MIDXW-1:0] x_mid5, n_sum, x_mid_next;
  logic [CNW-1:0] cn;
  logic [LOXW-1:0] x_lo;
  logic [CH_W-1:0] lo6, lo7, mid7;
  logic [HUE_W-1:0] hue_biased;
  rgb_beat_t rgb_next;

  assign busy = rst;

  // stage 1: bias hue to unsigned and push it into [0, 2^16 + T)
  assign hue_biased = {~hsv.hue[HUE_W-1], hsv.hue[HUE_W-2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:1], start};
    end
  end

  always_ff @(posedge clk) begin
    y1 <= YW'(hue_biased) + YW'(WRAP_OFFSET);
    s1 <= hsv.saturation;
    v1 <= hsv.brightness;
    a1 <= hsv.alpha_in;
  end

  hsv2rgb_cdiv #(
    .DIVISOR(T),
    .XW(YW),
    .QW(YQW)
  ) u_wrap (
    .clk(clk),
    .x(y1),
    .q(),
    .rem(w3)
  );

  // stage 2: chroma and value minus chroma, both in 1/255^2
  always_ff @(posedge clk) begin
    c2 <= PMW'(v1) * PMW'(s1);
    m2 <= PMW'(v1) * PMW'(CH_W'(CH_MAX) - s1);
    v2 <= v1;
    a2 <= a1;
  end

  always_ff @(posedge clk) begin
    c3 <= c2;
    m3 <= m2;
    v3 <= v2;
    a3 <= a2;
  end

  // stage 4: sector and secondary numerator
  always_comb begin
    sector_next = SEC_RY;
    base = '0;
    for (int k = 1; k < SECTOR_COUNT; k++) begin
      if (w3 >= WW'(k * U)) begin
        sector_next = sector_t'(k);
        base = WW'(k * U);
      end
    end
    rem_w = w3 - base;
    if (sector_next[0]) begin
      n_next = UW'(U) - UW'(rem_w);
    end else begin
      n_next = UW'(rem_w);
    end
  end

  always_ff @(posedge clk) begin
    sector4 <= sector_next;
    n4 <= n_next;
    c4 <= c3;
    m4 <= m3;
    v4 <= v3;
    a4 <= a3;
  end

  // smallest channel, 2m + 255 over 510
  assign x_lo = LOXW'({m4, 1'b0}) + LOXW'(CH_MAX);

  hsv2rgb_cdiv #(
    .DIVISOR(LO_DIV),
    .XW(LOXW),
    .QW(CH_W)
  ) u_lo (
    .clk(clk),
    .x(x_lo),
    .q(lo6),
    .rem()
  );

  // stage 5: middle channel numerator 2N + D
  assign cn = CNW'(c4) * CNW'(n4);
  assign n_sum = MIDXW'(cn) + MIDXW'(m4) * MIDXW'(U);
  assign x_mid_next = (n_sum << 1) + MIDXW'(D);

  always_ff @(posedge clk) begin
    x_mid5 <= x_mid_next;
    sector5 <= sector4;
    v5 <= v4;
    a5 <= a4;
  end

  hsv2rgb_cdiv #(
    .DIVISOR(MID_DIV),
    .XW(MIDXW),
    .QW(CH_W)
  ) u_mid (
    .clk(clk),
    .x(x_mid5),
    .q(mid7),
    .rem()
  );

  always_ff @(posedge clk) begin
    sector6 <= sector5;
    v6 <= v5;
    a6 <= a5;
  end

  always_ff @(posedge clk) begin
    sector7 <= sector6;
    lo7 <= lo6;
    v7 <= v6;
    a7 <= a6;
  end

  // channel placement by sector
  always_comb begin
    rgb_next.alpha_out = a7;
    unique case (sector7)
      SEC_RY: begin
        rgb_next.red = v7; rgb_next.green = mid7; rgb_next.blue = lo7;
      end
      SEC_YG: begin
        rgb_next.red = mid7; rgb_next.green = v7; rgb_next.blue = lo7;
      end
      SEC_GC: begin
        rgb_next.red = lo7; rgb_next.green = v7; rgb_next.blue = mid7;
      end
      SEC_CB: begin
        rgb_next.red = lo7; rgb_next.green = mid7; rgb_next.blue = v7;
      end
      SEC_BM: begin
        rgb_next.red = mid7; rgb_next.green = lo7; rgb_next.blue = v7;
      end
      default: begin
        rgb_next.red = v7; rgb_next.green = lo7; rgb_next.blue = mid7;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[7];
    end
  end

  always_ff @(posedge clk) begin
    rgb <= rgb_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##8 done)
    else $error("result beat missing eight cycles after command");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    start |-> ##8 (rgb.alpha_out == $past(hsv.alpha_in, 8)))
    else $error("alpha not carried with its pixel");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && hsv.saturation == '0) |->
      ##8 (rgb.red == rgb.green && rgb.green == rgb.blue))
    else $error("zero saturation gave unequal channels");

  a_sector: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (sector4 <= SEC_MR && n4 <= UW'(U)))
    else $error("sector or secondary numerator out of range");

endmodule

[tb/tb_top.sv]
module tb_top import hsv2rgb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HFB = HUE_FRACTION_BITS_DEFAULT;
  localparam longint SECTOR_SPAN = longint'(DEG_PER_SECTOR) << HFB;
  localparam longint TURN_SPAN = SECTOR_SPAN * longint'(SECTOR_COUNT);
  localparam longint CH_FULL = longint'(CH_MAX);
  localparam int RANDOM_PIXELS = 1350;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  hsv_beat_t pixel_in = '0;
  rgb_beat_t pixel_out;

  hsv_beat_t pixel_queue[$];
  rgb_beat_t rgb_expected[$];
  rgb_beat_t rgb_want;
  int beats_in = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  hsv_to_rgb_converter_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .hsv(pixel_in),
    .done(done),
    .rgb(pixel_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // exact rational hsv to rgb, rounded half up
  function automatic rgb_beat_t hsv_to_rgb_predict(hsv_beat_t px);
    longint angle, wrapped, offset, ramp, sat, val, top, bottom, middle;
    sector_t sec;
    rgb_beat_t res;
    angle = longint'($signed(px.hue));
    wrapped = angle % TURN_SPAN;
    if (wrapped < 0) begin
      wrapped = wrapped + TURN_SPAN;
    end
    sec = sector_t'(wrapped / SECTOR_SPAN);
    offset = wrapped % SECTOR_SPAN;
    ramp = ((wrapped / SECTOR_SPAN) % 2 == 1) ? SECTOR_SPAN - offset : offset;
    sat = longint'(px.saturation);
    val = longint'(px.brightness);
    top = val;
    bottom = (2 * val * (CH_FULL - sat) + CH_FULL) / (2 * CH_FULL);
    middle = (2 * (val * sat * ramp + val * (CH_FULL - sat) * SECTOR_SPAN)
              + CH_FULL * SECTOR_SPAN) / (2 * CH_FULL * SECTOR_SPAN);
    case (sec)
      SEC_RY: begin
        res.red = CH_W'(top); res.green = CH_W'(middle); res.blue = CH_W'(bottom);
      end
      SEC_YG: begin
        res.red = CH_W'(middle); res.green = CH_W'(top); res.blue = CH_W'(bottom);
      end
      SEC_GC: begin
        res.red = CH_W'(bottom); res.green = CH_W'(top); res.blue = CH_W'(middle);
      end
      SEC_CB: begin
        res.red = CH_W'(bottom); res.green = CH_W'(middle); res.blue = CH_W'(top);
      end
      SEC_BM: begin
        res.red = CH_W'(middle); res.green = CH_W'(bottom); res.blue = CH_W'(top);
      end
      default: begin
        res.red = CH_W'(top); res.green = CH_W'(bottom); res.blue = CH_W'(middle);
      end
    endcase
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  task automatic queue_pixel(int hue, int sat, int val, int alpha);
    hsv_beat_t px;
    px.hue = HUE_W'(hue);
    px.saturation = CH_W'(sat);
    px.brightness = CH_W'(val);
    px.alpha_in = CH_W'(alpha);
    pixel_queue.push_back(px);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rgb_expected.push_back(hsv_to_rgb_predict(pixel_in));
        beats_in <= beats_in + 1;
      end
      if (!start || !busy) begin
        if (pixel_queue.size() != 0 &&
            ((beats_in >= 700 && beats_in < 1000) || $urandom_range(0, 99) >= 28)) begin
          pixel_in <= pixel_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (rgb_expected.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: result beat with nothing pending: r %0d g %0d b %0d a %0d",
                   $realtime, pixel_out.red, pixel_out.green, pixel_out.blue,
                   pixel_out.alpha_out);
        end
        mismatches <= mismatches + 1;
      end else begin
        rgb_want = rgb_expected.pop_front();
        if (pixel_out.red !== rgb_want.red || pixel_out.green !== rgb_want.green ||
            pixel_out.blue !== rgb_want.blue ||
            pixel_out.alpha_out !== rgb_want.alpha_out) begin
          if (mismatches < 10) begin
            $display("%0t: mismatch exp r %0d g %0d b %0d a %0d, got r %0d g %0d b %0d a %0d",
                     $realtime, rgb_want.red, rgb_want.green, rgb_want.blue,
                     rgb_want.alpha_out, pixel_out.red, pixel_out.green,
                     pixel_out.blue, pixel_out.alpha_out);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // directed: extremes, sector edges, wraps
    queue_pixel(0, 255, 255, 0);
    queue_pixel(960, 255, 255, 255);
    queue_pixel(1920, 255, 200, 17);
    queue_pixel(2880, 255, 200, 34);
    queue_pixel(3840, 255, 200, 51);
    queue_pixel(4800, 255, 200, 68);
    queue_pixel(5760, 255, 200, 85);
    queue_pixel(-1, 255, 255, 102);
    queue_pixel(-960, 200, 255, 119);
    queue_pixel(-5760, 180, 90, 136);
    queue_pixel(-32768, 255, 255, 153);
    queue_pixel(32767, 255, 255, 170);
    queue_pixel(959, 255, 255, 187);
    queue_pixel(961, 255, 255, 204);
    queue_pixel(480, 128, 128, 221);
    queue_pixel(1234, 0, 177, 238);
    queue_pixel(-20000, 0, 255, 255);
    queue_pixel(2400, 255, 0, 1);
    queue_pixel(4321, 0, 0, 2);
    queue_pixel(28800, 100, 250, 3);
    queue_pixel(-28801, 1, 254, 4);
    queue_pixel(2881, 254, 1, 5);
    queue_pixel(5279, 77, 133, 6);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        // near a sector edge, anywhere in the hue range
        queue_pixel(int'($urandom_range(0, 67)) * 960 - 32640 + int'($urandom_range(0, 2)) - 1,
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        queue_pixel(int'($urandom_range(0, 65535)), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pixel_queue.size() != 0 || start) @(posedge clk);
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_cdiv.sv
sv/hsv_to_rgb_converter_core.sv
tb/tb_top.sv
